FILE: sv/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg
// Types, command codes and match tables shared by the command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

	localparam int BYTE_W    = 8;
	localparam int CMD_W     = 3;
	localparam int NCMD      = 7;
	localparam int POS_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int OUT_PER_W = 16;

	// Command codes as reported on the result channel
	typedef enum logic [CMD_W-1:0] {
		CMD_SCALE   = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_OFF     = 3'd3,
		CMD_PERIOD  = 3'd4,
		CMD_LOG     = 3'd5,
		CMD_INVALID = 3'd6
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SCALE  = 2'd1;

	// Match flag positions
	localparam int FLAG_SCALE_F = 0;
	localparam int FLAG_SCALE_C = 1;
	localparam int FLAG_START   = 2;
	localparam int FLAG_STOP    = 3;
	localparam int FLAG_OFF     = 4;
	localparam int FLAG_PERIOD  = 5;
	localparam int FLAG_LOG     = 6;

	localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

	localparam logic [POS_W-1:0] POS_MAX           = 7'd127;
	localparam logic [POS_W-1:0] PERIOD_PREFIX_LEN = 7'd7;
	localparam logic [POS_W-1:0] LOG_PREFIX_LEN    = 7'd3;
	localparam logic [POS_W-1:0] SCALE_LEN         = 7'd7;
	localparam logic [POS_W-1:0] START_LEN         = 7'd5;
	localparam logic [POS_W-1:0] STOP_LEN          = 7'd4;
	localparam logic [POS_W-1:0] OFF_LEN           = 7'd3;

	// Command text, one row per flag, padded with NUL
	localparam logic [BYTE_W-1:0] CMD_TEXT [NCMD][8] = '{
		'{"S", "C", "A", "L", "E", "=", "F", 8'h00},
		'{"S", "C", "A", "L", "E", "=", "C", 8'h00},
		'{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
		'{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "E", "R", "I", "O", "D", "=", 8'h00},
		'{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] CMD_LEN [NCMD] = '{3'd7, 3'd7, 3'd5, 3'd4, 3'd3, 3'd7, 3'd3};
	// Commands that must end right after their text
	localparam logic [NCMD-1:0] CMD_EXACT = 7'b0011111;

	// Per-line matching state
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [NCMD-1:0]  flags;
		logic             digits_ok;
	} line_st_t;

	localparam line_st_t LINE_RST = '{pos: '0, flags: '1, digits_ok: 1'b1};

	// Matcher outcome for one byte
	typedef struct packed {
		line_st_t   nxt;
		logic       nl;
		cmd_t       cmd;
		logic       scale_c;
		logic       digit_en;
		logic [3:0] digit;
	} match_res_t;

endpackage

FILE: sv/scld_rx_if.sv
// ----------------------------------------------------------------------------
// scld_rx_if
// Received byte channel: valid/ready handshake carrying one character.
// ----------------------------------------------------------------------------
interface scld_rx_if;
	import scld_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/scld_res_if.sv
// ----------------------------------------------------------------------------
// scld_res_if
// Result channel: one beat per decoded command line.
// ----------------------------------------------------------------------------
interface scld_res_if;
	import scld_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic                 scale_now;
	logic [OUT_PER_W-1:0] period_now;
	logic                 report_on;
	logic                 shutdown;
	logic                 logged;

	modport source (output valid, output command, output scale_now, output period_now,
		output report_on, output shutdown, output logged, input ready);
	modport sink (input valid, input command, input scale_now, input period_now,
		input report_on, input shutdown, input logged, output ready);
endinterface

FILE: sv/scld_cfg_if.sv
// ----------------------------------------------------------------------------
// scld_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scld_cfg_if;
	import scld_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/sensor_command_line_decoder.sv
// ----------------------------------------------------------------------------
// sensor_command_line_decoder
// Decodes newline-terminated command lines from a received byte stream.
// ----------------------------------------------------------------------------
// A newline passes through the byte register, then into the result register once the result slot is free.
// Throughput: one byte per cycle; the byte register and the result register
// stall together only when a result is waiting and the next newline arrives.
// Reset: arst_n clears line state, sets period to 1, scale to Fahrenheit,
// reporting on. After an OFF line all bytes are dropped until reset.
module sensor_command_line_decoder #(
	parameter int PERIOD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	scld_rx_if.sink          rx,
	scld_res_if.source       res,
	scld_cfg_if.sink         cfg
);
	import scld_pkg::*;

	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Decoder state
	line_st_t               line_q;
	logic [PERIOD_BITS-1:0] acc_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic                   scale_q;
	logic                   report_q;
	logic                   halted_q;

	// Result register
	logic                 res_valid_q;
	cmd_t                 cmd_s2;
	logic                 scale_s2;
	logic [OUT_PER_W-1:0] period_s2;
	logic                 report_s2;
	logic                 shut_s2;
	logic                 logged_s2;

	match_res_t             mr;
	logic                   nl_go;
	logic                   can_adv;
	logic                   adv_s1;
	logic [PERIOD_BITS+3:0] acc_mul;
	logic [PERIOD_BITS-1:0] acc_nx;
	logic [PERIOD_BITS-1:0] period_n;
	logic                   scale_n;
	logic                   report_n;
	logic                   halted_n;
	logic [31:0]            period_w;
	logic [31:0]            cfg_w;

	scld_line_match u_match (
		.cur     (line_q),
		.rx_byte (byte_s1),
		.mr      (mr)
	);

	// Handshake: a newline needs a free result slot
	assign nl_go    = valid_s1 && !halted_q && mr.nl;
	assign can_adv  = !res_valid_q || res.ready;
	assign adv_s1   = valid_s1 && (!nl_go || can_adv);
	assign rx.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	// Decimal accumulate with saturation
	assign acc_mul = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
		{{PERIOD_BITS{1'b0}}, mr.digit};
	assign acc_nx  = (acc_mul[PERIOD_BITS+3:PERIOD_BITS] != 4'b0) ? PERIOD_MAX :
		acc_mul[PERIOD_BITS-1:0];

	// Settings after the finished line
	always_comb begin
		period_n = period_q;
		scale_n  = scale_q;
		report_n = report_q;
		halted_n = halted_q;
		unique case (mr.cmd)
			CMD_SCALE:  scale_n  = mr.scale_c;
			CMD_START:  report_n = 1'b1;
			CMD_STOP:   report_n = 1'b0;
			CMD_OFF:    halted_n = 1'b1;
			CMD_PERIOD: period_n = acc_q;
			default:    ;
		endcase
	end

	assign period_w = 32'(period_n);
	assign cfg_w    = 32'(cfg.data);

	// Hold the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	// Advance line state and settings; configuration loads settings directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= LINE_RST;
			acc_q    <= '0;
			period_q <= PERIOD_BITS'(1);
			scale_q  <= 1'b0;
			report_q <= 1'b1;
			halted_q <= 1'b0;
		end else begin
			if (adv_s1 && !halted_q) begin
				line_q <= mr.nxt;
				if (mr.nl) begin
					acc_q    <= '0;
					period_q <= period_n;
					scale_q  <= scale_n;
					report_q <= report_n;
					halted_q <= halted_n;
				end else if (mr.digit_en) begin
					acc_q <= acc_nx;
				end
			end
			if (cfg.valid) begin
				if (cfg.index == CFG_START_PERIOD)
					period_q <= cfg_w[PERIOD_BITS-1:0];
				else if (cfg.index == CFG_START_SCALE)
					scale_q <= cfg.data[0];
			end
		end
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (nl_go && can_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (nl_go && can_adv) begin
			cmd_s2    <= mr.cmd;
			scale_s2  <= scale_n;
			period_s2 <= period_w[OUT_PER_W-1:0];
			report_s2 <= report_n;
			shut_s2   <= (mr.cmd == CMD_OFF);
			logged_s2 <= (mr.cmd != CMD_INVALID);
		end
	end

	assign res.valid      = res_valid_q;
	assign res.command    = cmd_s2;
	assign res.scale_now  = scale_s2;
	assign res.period_now = period_s2;
	assign res.report_on  = report_s2;
	assign res.shutdown   = shut_s2;
	assign res.logged     = logged_s2;

	// A shutdown result leaves the decoder halted
	a_shut_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && shut_s2 |-> halted_q)
		else $error("shutdown result without halt");

	// Nothing is decoded once halted
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> !(res_valid_q && !$past(res_valid_q)))
		else $error("result produced while halted");

	// A decoded line leaves a clean line state
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		nl_go && can_adv |=> (line_q == LINE_RST) && (acc_q == '0))
		else $error("line state not cleared after newline");

	// Logged tracks validity of the command
	a_logged: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (logged_s2 == (cmd_s2 != CMD_INVALID)))
		else $error("logged flag inconsistent with command");

endmodule

FILE: sv/scld_line_match.sv
// ----------------------------------------------------------------------------
// scld_line_match
// Incremental prefix matcher: advances the line state by one byte and
// decodes the finished line when the byte is a newline.
// ----------------------------------------------------------------------------
module scld_line_match (
	input  scld_pkg::line_st_t          cur,
	input  logic [scld_pkg::BYTE_W-1:0] rx_byte,
	output scld_pkg::match_res_t        mr
);
	import scld_pkg::*;

	logic is_nl;
	logic is_dig;
	logic past_prefix;

	assign is_nl       = (rx_byte == CHAR_NL);
	assign is_dig      = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign past_prefix = (cur.pos >= PERIOD_PREFIX_LEN);

	always_comb begin
		mr          = '0;
		mr.nl       = is_nl;
		mr.nxt      = cur;
		mr.scale_c  = cur.flags[FLAG_SCALE_C];
		mr.digit    = rx_byte[3:0];
		mr.digit_en = past_prefix && is_dig && !is_nl;

		// Drop every command whose text no longer fits the line
		for (int k = 0; k < NCMD; k++) begin
			if (cur.flags[k]) begin
				if (cur.pos < {4'b0, CMD_LEN[k]}) begin
					if (rx_byte != CMD_TEXT[k][cur.pos[2:0]])
						mr.nxt.flags[k] = 1'b0;
				end else if (CMD_EXACT[k]) begin
					mr.nxt.flags[k] = 1'b0;
				end
			end
		end

		// Any non-digit after PERIOD= spoils the value
		if (past_prefix && !is_dig)
			mr.nxt.digits_ok = 1'b0;

		if (cur.pos < POS_MAX)
			mr.nxt.pos = cur.pos + 7'd1;

		// Decode the finished line
		priority if ((cur.flags[FLAG_SCALE_F] || cur.flags[FLAG_SCALE_C]) &&
				cur.pos == SCALE_LEN) begin
			mr.cmd = CMD_SCALE;
		end else if (cur.flags[FLAG_START] && cur.pos == START_LEN) begin
			mr.cmd = CMD_START;
		end else if (cur.flags[FLAG_STOP] && cur.pos == STOP_LEN) begin
			mr.cmd = CMD_STOP;
		end else if (cur.flags[FLAG_OFF] && cur.pos == OFF_LEN) begin
			mr.cmd = CMD_OFF;
		end else if (cur.flags[FLAG_PERIOD] && cur.pos > PERIOD_PREFIX_LEN) begin
			mr.cmd = cur.digits_ok ? CMD_PERIOD : CMD_INVALID;
		end else if (cur.flags[FLAG_LOG] && cur.pos > LOG_PREFIX_LEN) begin
			mr.cmd = CMD_LOG;
		end else begin
			mr.cmd = CMD_INVALID;
		end

		// Newline starts a fresh line
		if (is_nl)
			mr.nxt = LINE_RST;
	end
endmodule
